FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ESA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("esa check failed");

// next-cycle implication, disabled while reset is low
`define ESA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("esa check failed");

`endif

FILE: hdl/esa_pkg.sv
// shared constants and types of the edge scatter spmv accumulator
// no dependencies
package esa_pkg;

    localparam int CELLS_MAX_DEF  = 4096;
    localparam int VALUE_BITS_DEF = 32;
    localparam int DATA_W         = 32;
    localparam int IDX_W          = 12;
    localparam int CFG_W          = 13;
    localparam int REQ_W          = 2;
    localparam int CFG_RESET      = 4096;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE  = 2'd0,
        REQ_EDGE   = 2'd1,
        REQ_COMMIT = 2'd2,
        REQ_READ   = 2'd3
    } t_req;

endpackage

FILE: hdl/esa_ram.sv
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module esa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/edge_scatter_spmv_accumulate_top.sv
// edge scatter spmv accumulator: cell value and matvec memories under one sequencer
// depends on esa_pkg and esa_ram
//
// One item is taken when start is high and busy is low; its single result shows for one
// cycle with o_done and cannot be held off. Writes, items with a bad index and a commit
// whose accumulator is already clear answer in the next cycle. A read passes S_RD_WAIT and
// S_RD_OUT while the registered memories are read. An edge reuses one 32x32 multiplier
// once per 32-bit slice of the cell value, then scales and does a saturating
// read-modify-write of the accumulator. The first edge after a commit first clears the
// whole accumulator memory, unless it is already clear. A commit walks the cells in use
// through S_CM_RD and S_CM_WR, or clears the accumulator when no edge came since the last
// commit. After reset busy stays high while the accumulator memory is cleared; the
// cell_count register can be written during that time.
module edge_scatter_spmv_accumulate_top #(
    parameter int CELLS_MAX  = esa_pkg::CELLS_MAX_DEF,
    parameter int VALUE_BITS = esa_pkg::VALUE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cfg_we,
    input  logic        [esa_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic        [esa_pkg::REQ_W-1:0]   i_req_type,
    input  logic        [esa_pkg::IDX_W-1:0]   i_cell_index,
    input  logic signed [esa_pkg::DATA_W-1:0]  i_cell_value,
    input  logic        [esa_pkg::IDX_W-1:0]   i_source_cell,
    input  logic        [esa_pkg::IDX_W-1:0]   i_target_cell,
    input  logic signed [esa_pkg::DATA_W-1:0]  i_edge_weight,
    output logic                               o_done,
    output logic signed [esa_pkg::DATA_W-1:0]  o_height_value,
    output logic signed [esa_pkg::DATA_W-1:0]  o_matvec_value,
    output logic                               o_status
);

    import esa_pkg::*;

    localparam int VB      = VALUE_BITS;
    localparam int AW      = $clog2(CELLS_MAX);
    localparam int CNTW    = $clog2(CELLS_MAX + 1);
    localparam int CMPW    = (CNTW > IDX_W) ? CNTW : IDX_W;
    localparam int CFGCW   = (CNTW > CFG_W) ? CNTW : CFG_W;
    localparam int CNT_RST = (CELLS_MAX < CFG_RESET) ? CELLS_MAX : CFG_RESET;
    localparam int NCH     = (VB + 31) / 32;
    localparam int MPW     = NCH * 32;
    localparam int PW      = MPW + 32;
    localparam int KW      = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int WW      = (VB > DATA_W) ? VB : DATA_W;

    localparam logic        [VB-1:0] VMAX_U = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VMAX   = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VMIN   = {1'b1, {(VB-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_E_WAIT,
        S_E_LOAD,
        S_MUL,
        S_ACC,
        S_SCALE,
        S_SUM,
        S_RD_WAIT,
        S_RD_OUT,
        S_CM_RD,
        S_CM_WR
    } t_state;

    typedef enum logic [1:0] {
        POST_NONE,
        POST_EDGE,
        POST_COMMIT
    } t_post;

    function automatic logic signed [VB-1:0] sat_add(input logic signed [VB-1:0] a,
                                                     input logic signed [VB-1:0] b);
        logic signed [VB:0] s;
        s = (VB+1)'(a) + (VB+1)'(b);
        if (s[VB] != s[VB-1]) begin
            sat_add = s[VB] ? VMIN : VMAX;
        end else begin
            sat_add = s[VB-1:0];
        end
    endfunction

    function automatic logic signed [VB-1:0] clamp_in(input logic signed [DATA_W-1:0] x);
        logic signed [WW-1:0] xw;
        logic signed [WW-1:0] hi;
        logic signed [WW-1:0] lo;
        xw = WW'(x);
        hi = WW'(VMAX);
        lo = WW'(VMIN);
        if (xw > hi) begin
            clamp_in = VMAX;
        end else if (xw < lo) begin
            clamp_in = VMIN;
        end else begin
            clamp_in = VB'(xw);
        end
    endfunction

    t_state                    r_state;
    t_post                     r_post;
    logic [AW-1:0]             r_clr_idx;
    logic [AW-1:0]             r_raddr_h;
    logic [AW-1:0]             r_raddr_m;
    logic [CNTW-1:0]           r_count;
    logic                      r_pending;
    logic                      r_clean;
    logic signed [DATA_W-1:0]  r_weight;
    logic signed [VB-1:0]      r_mv_old;
    logic                      r_neg;
    logic [MPW-1:0]            r_mvp;
    logic [31:0]               r_mw;
    logic [63:0]               r_prod;
    logic [PW-1:0]             r_acc;
    logic [KW-1:0]             r_k;
    logic signed [VB-1:0]      r_p;
    logic                      r_done;
    logic                      r_status;
    logic signed [DATA_W-1:0]  r_hv;
    logic signed [DATA_W-1:0]  r_mvv;

    logic                      accept;
    logic                      ci_ok;
    logic                      src_ok;
    logic                      dst_ok;
    logic [CFGCW-1:0]          cfg_ext;
    logic [CNTW-1:0]           cfg_count;

    logic                      h_we;
    logic [AW-1:0]             h_waddr;
    logic [VB-1:0]             h_wdata;
    logic [VB-1:0]             h_rdata;
    logic                      m_we;
    logic [AW-1:0]             m_waddr;
    logic [VB-1:0]             m_wdata;
    logic [VB-1:0]             m_rdata;

    logic [VB-1:0]             mag_h;
    logic [31:0]               mag_w;
    logic [PW-1:0]             rnd;
    logic [PW-17:0]            q;
    logic [PW-17:0]            lim;
    logic [PW-17:0]            qs;
    logic signed [VB-1:0]      scaled;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign ci_ok  = CMPW'(i_cell_index)  < CMPW'(r_count);
    assign src_ok = CMPW'(i_source_cell) < CMPW'(r_count);
    assign dst_ok = CMPW'(i_target_cell) < CMPW'(r_count);

    always_comb begin
        cfg_ext = CFGCW'(i_cfg_wdata);
        priority if (cfg_ext == '0) begin
            cfg_count = CNTW'(1);
        end else if (cfg_ext > CFGCW'(CELLS_MAX)) begin
            cfg_count = CNTW'(CELLS_MAX);
        end else begin
            cfg_count = CNTW'(cfg_ext);
        end
    end

    // magnitudes feed the unsigned slice multiplier
    assign mag_h = h_rdata[VB-1] ? (~h_rdata + VB'(1)) : h_rdata;
    assign mag_w = r_weight[DATA_W-1] ? (~r_weight + 32'd1) : r_weight;

    // rounding the magnitude up for negative products gives floor of the signed product
    always_comb begin
        rnd    = r_neg ? (r_acc + PW'(16'hFFFF)) : r_acc;
        q      = rnd[PW-1:16];
        lim    = (PW-16)'(VMAX_U) + (PW-16)'(r_neg);
        qs     = (q > lim) ? lim : q;
        scaled = r_neg ? (~VB'(qs) + VB'(1)) : VB'(qs);
    end

    always_comb begin
        h_we    = 1'b0;
        h_waddr = r_raddr_h;
        h_wdata = sat_add($signed(h_rdata), $signed(m_rdata));
        m_we    = 1'b0;
        m_waddr = r_clr_idx;
        m_wdata = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (t_req'(i_req_type) == REQ_WRITE) && ci_ok) begin
                    h_we    = 1'b1;
                    h_waddr = AW'(i_cell_index);
                    h_wdata = clamp_in(i_cell_value);
                end
            end
            S_CM_WR: begin
                h_we = 1'b1;
            end
            S_CLEAR: begin
                m_we = 1'b1;
            end
            S_SUM: begin
                m_we    = 1'b1;
                m_waddr = r_raddr_m;
                m_wdata = sat_add(r_mv_old, r_p);
            end
            default: begin
            end
        endcase
    end

    esa_ram #(
        .WIDTH (VB),
        .DEPTH (CELLS_MAX)
    ) u_height_ram (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_raddr (r_raddr_h),
        .o_rdata (h_rdata)
    );

    esa_ram #(
        .WIDTH (VB),
        .DEPTH (CELLS_MAX)
    ) u_matvec_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (r_raddr_m),
        .o_rdata (m_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_post    <= POST_NONE;
            r_clr_idx <= '0;
            r_count   <= CNTW'(CNT_RST);
            r_pending <= 1'b1;
            r_clean   <= 1'b0;
            r_done    <= 1'b0;
            r_status  <= 1'b0;
            r_hv      <= '0;
            r_mvv     <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_count <= cfg_count;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_raddr_h <= AW'(i_source_cell);
                        r_raddr_m <= AW'(i_target_cell);
                        r_weight  <= i_edge_weight;
                        r_hv      <= '0;
                        r_mvv     <= '0;
                        r_status  <= 1'b0;
                        unique case (t_req'(i_req_type))
                            REQ_WRITE: begin
                                r_done   <= 1'b1;
                                r_status <= !ci_ok;
                            end
                            REQ_EDGE: begin
                                if (src_ok && dst_ok) begin
                                    r_pending <= 1'b0;
                                    if (r_pending && !r_clean) begin
                                        r_state   <= S_CLEAR;
                                        r_post    <= POST_EDGE;
                                        r_clr_idx <= '0;
                                    end else begin
                                        r_state <= S_E_WAIT;
                                    end
                                end else begin
                                    r_done   <= 1'b1;
                                    r_status <= 1'b1;
                                end
                            end
                            REQ_COMMIT: begin
                                r_pending <= 1'b1;
                                if (r_pending) begin
                                    if (r_clean) begin
                                        r_done <= 1'b1;
                                    end else begin
                                        r_state   <= S_CLEAR;
                                        r_post    <= POST_COMMIT;
                                        r_clr_idx <= '0;
                                    end
                                end else begin
                                    r_raddr_h <= '0;
                                    r_raddr_m <= '0;
                                    r_state   <= S_CM_RD;
                                end
                            end
                            REQ_READ: begin
                                if (ci_ok) begin
                                    r_raddr_h <= AW'(i_cell_index);
                                    r_raddr_m <= AW'(i_cell_index);
                                    r_state   <= S_RD_WAIT;
                                end else begin
                                    r_done   <= 1'b1;
                                    r_status <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + AW'(1);
                    if (r_clr_idx == AW'(CELLS_MAX - 1)) begin
                        r_clean <= 1'b1;
                        unique case (r_post)
                            POST_EDGE: begin
                                r_state <= S_E_WAIT;
                            end
                            POST_COMMIT: begin
                                r_done   <= 1'b1;
                                r_status <= 1'b0;
                                r_hv     <= '0;
                                r_mvv    <= '0;
                                r_state  <= S_IDLE;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_E_WAIT: begin
                    r_state <= S_E_LOAD;
                end
                S_E_LOAD: begin
                    r_mv_old <= $signed(m_rdata);
                    r_neg    <= h_rdata[VB-1] ^ r_weight[DATA_W-1];
                    r_mvp    <= MPW'(mag_h);
                    r_mw     <= mag_w;
                    r_acc    <= '0;
                    r_k      <= KW'(NCH - 1);
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    // most significant slice first
                    r_prod  <= r_mvp[MPW-1 -: 32] * r_mw;
                    r_mvp   <= r_mvp << 32;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= (r_acc << 32) + PW'(r_prod);
                    if (r_k == '0) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_k     <= r_k - KW'(1);
                        r_state <= S_MUL;
                    end
                end
                S_SCALE: begin
                    r_p     <= scaled;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_clean  <= 1'b0;
                    r_done   <= 1'b1;
                    r_status <= 1'b0;
                    r_hv     <= '0;
                    r_mvv    <= '0;
                    r_state  <= S_IDLE;
                end
                S_RD_WAIT: begin
                    r_state <= S_RD_OUT;
                end
                S_RD_OUT: begin
                    r_done   <= 1'b1;
                    r_status <= 1'b0;
                    r_hv     <= DATA_W'($signed(h_rdata));
                    r_mvv    <= DATA_W'($signed(m_rdata));
                    r_state  <= S_IDLE;
                end
                S_CM_RD: begin
                    r_state <= S_CM_WR;
                end
                S_CM_WR: begin
                    r_raddr_h <= r_raddr_h + AW'(1);
                    r_raddr_m <= r_raddr_m + AW'(1);
                    if (CNTW'(r_raddr_h) + CNTW'(1) == r_count) begin
                        r_done   <= 1'b1;
                        r_status <= 1'b0;
                        r_hv     <= '0;
                        r_mvv    <= '0;
                        r_state  <= S_IDLE;
                    end else begin
                        r_state <= S_CM_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_height_value = r_hv;
    assign o_matvec_value = r_mvv;

endmodule

FILE: hdl/esa_checker.sv
// port-level checks of the edge scatter spmv accumulator, bound to the top level
// depends on esa_pkg and assert_macros.svh
`include "assert_macros.svh"

module esa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic        [esa_pkg::REQ_W-1:0]  i_req_type,
    input logic                              o_done,
    input logic                              o_status,
    input logic signed [esa_pkg::DATA_W-1:0] o_height_value,
    input logic signed [esa_pkg::DATA_W-1:0] o_matvec_value
);

    import esa_pkg::*;

    // a result transfer always leaves the block ready
    `ESA_ASSERT_IMPL(a_done_ready, i_clk, i_rst_n, o_done, !busy)

    // dropped items carry zero value fields
    `ESA_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_done && o_status, o_height_value == 0 && o_matvec_value == 0)

    // a write answers in the next cycle with zero value fields
    `ESA_ASSERT_NEXT(a_write_next, i_clk, i_rst_n, start && !busy && i_req_type == REQ_WRITE, o_done && !busy && o_height_value == 0 && o_matvec_value == 0)

endmodule

bind edge_scatter_spmv_accumulate_top esa_checker u_esa_checker (.*);
